>>> sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// sse_pkg
// Shared types, codes and constants for the stepwise sort engine.
// ----------------------------------------------------------------------------
package sse_pkg;

    // default sizing
    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 16;

    // fixed field widths of the stream and config ports
    localparam int REQ_W       = 2;
    localparam int IDX_W       = 6;
    localparam int DATA_W      = 16;
    localparam int ALG_W       = 2;
    localparam int COUNT_W     = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int OUT_PAD_W   = M_TDATA_W - (1 + IDX_W + IDX_W + 1 + DATA_W);

    // reset value of the element count register
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // config register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ALGORITHM = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COUNT     = 1'b1;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_READ    = 2'd3
    } req_t;

    // sort algorithms
    typedef enum logic [ALG_W-1:0] {
        ALG_EXCHANGE  = 2'd0,
        ALG_SELECTION = 2'd1,
        ALG_INSERTION = 2'd2,
        ALG_GNOME     = 2'd3
    } alg_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic load_write;
        logic read_issue;
        logic restart;
        logic step_read;
        logic step_commit;
        logic swap_read;
        logic write_a;
        logic write_b;
        logic out_load;
    } sse_cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_t req;
        logic swap_needed;
        logic out_free;
    } sse_status_t;

endpackage

>>> sv/sse_ctrl.sv
// ----------------------------------------------------------------------------
// sse_ctrl
// Request sequencer: accepts one beat, walks it through memory access,
// compare, exchange and result hand-off.
// ----------------------------------------------------------------------------
module sse_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sse_pkg::sse_status_t status,
    output sse_pkg::sse_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EXEC    = 7'b0000010,
        ST_COMPARE = 7'b0000100,
        ST_SWAP_RD = 7'b0001000,
        ST_SWAP_WA = 7'b0010000,
        ST_SWAP_WB = 7'b0100000,
        ST_RESULT  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (status.req)
                    sse_pkg::REQ_LOAD:
                    begin
                        cmd.load_write = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    sse_pkg::REQ_STEP:
                    begin
                        cmd.step_read = 1'b1;
                        state_next    = ST_COMPARE;
                    end
                    sse_pkg::REQ_RESTART:
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_RESULT;
                    end
                    default:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = ST_RESULT;
                    end
                endcase
            end
            ST_COMPARE:
            begin
                cmd.step_commit = 1'b1;
                state_next      = status.swap_needed ? ST_SWAP_RD : ST_RESULT;
            end
            ST_SWAP_RD:
            begin
                cmd.swap_read = 1'b1;
                state_next    = ST_SWAP_WA;
            end
            ST_SWAP_WA:
            begin
                cmd.write_a = 1'b1;
                state_next  = ST_SWAP_WB;
            end
            ST_SWAP_WB:
            begin
                cmd.write_b = 1'b1;
                state_next  = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/sse_datapath.sv
// ----------------------------------------------------------------------------
// sse_datapath
// Element memory, sort position registers, step decision logic and the
// output register.
// ----------------------------------------------------------------------------
module sse_datapath #(
    parameter int MAX_ELEMENTS = sse_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = sse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sse_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sse_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sse_pkg::req_t                       in_req,
    input  logic [sse_pkg::IDX_W-1:0]           in_index,
    input  logic [sse_pkg::DATA_W-1:0]          in_value,
    input  sse_pkg::sse_cmd_t                   cmd,
    output sse_pkg::sse_status_t                status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sse_pkg::M_TDATA_W-1:0]       out_data
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int SW = CW + 2;
    localparam int IW = sse_pkg::IDX_W;
    localparam int DW = sse_pkg::DATA_W;

    typedef logic signed [SW-1:0] spos_t;

    // element memory, two read ports and one write port
    logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];

    // config registers
    sse_pkg::alg_t                algorithm_reg;
    logic [sse_pkg::COUNT_W-1:0]  count_reg;

    // captured request
    sse_pkg::req_t                req_reg;
    logic [IW-1:0]                idx_reg;
    logic [DW-1:0]                value_reg;

    // sort state
    logic [CW-1:0]                outer_reg;
    logic [CW-1:0]                outer_next;
    logic signed [CW:0]           inner_reg;
    logic signed [CW:0]           inner_next;
    logic [CW-1:0]                minimum_reg;
    logic [CW-1:0]                minimum_next;
    logic                         done_reg;
    logic                         done_next;

    // read data and pending exchange
    logic [VALUE_WIDTH-1:0]       rd_a_reg;
    logic [VALUE_WIDTH-1:0]       rd_b_reg;
    logic [AW-1:0]                swap_a_reg;
    logic [AW-1:0]                swap_b_reg;
    logic                         swap_flag_reg;

    // output register
    logic                         out_valid_reg;
    logic [sse_pkg::M_TDATA_W-1:0] out_data_reg;

    // combinational helpers
    logic [31:0]                  count_wide;
    logic [31:0]                  n_wide;
    spos_t                        n_s;
    spos_t                        i_s;
    spos_t                        j_s;
    spos_t                        m_s;
    spos_t                        mf_s;
    spos_t                        gp_s;
    spos_t                        pa_s;
    spos_t                        pb_s;
    spos_t                        io_s;
    spos_t                        jo_s;
    spos_t                        mo_s;
    spos_t                        sa_s;
    spos_t                        sb_s;
    logic                         swap_go;
    logic                         swap_needed;
    logic                         gt;
    logic [AW+IW-1:0]             idx_wide;
    logic [AW-1:0]                idx_addr;
    logic                         idx_in_range;
    logic [VALUE_WIDTH+DW-1:0]    value_wide;
    logic [DW+VALUE_WIDTH-1:0]    read_wide;
    logic [DW-1:0]                read_field;
    logic [IW+AW-1:0]             first_wide;
    logic [IW+AW-1:0]             second_wide;
    logic [IW-1:0]                first_field;
    logic [IW-1:0]                second_field;
    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                mem_waddr;
    logic [VALUE_WIDTH-1:0]       mem_wdata;
    logic [AW-1:0]                mem_raddr_a;
    logic [AW-1:0]                mem_raddr_b;

    // active element count, clamped to 1..MAX_ELEMENTS
    always_comb
    begin
        count_wide = 32'(count_reg);
        if (count_reg == '0)
        begin
            n_wide = 32'd1;
        end
        else if (count_wide > 32'(MAX_ELEMENTS))
        begin
            n_wide = 32'(MAX_ELEMENTS);
        end
        else
        begin
            n_wide = count_wide;
        end
    end

    assign n_s  = $signed(n_wide[SW-1:0]);
    assign i_s  = $signed({2'b00, outer_reg});
    assign j_s  = $signed({inner_reg[CW], inner_reg});
    assign m_s  = $signed({2'b00, minimum_reg});
    assign mf_s = (m_s >= n_s) ? i_s : m_s;
    assign gp_s = (i_s == spos_t'(0)) ? spos_t'(1) : i_s;

    // compare pair of the current step
    always_comb
    begin
        case (algorithm_reg)
            sse_pkg::ALG_EXCHANGE:
            begin
                pa_s = i_s;
                pb_s = j_s;
            end
            sse_pkg::ALG_SELECTION:
            begin
                pa_s = mf_s;
                pb_s = j_s;
            end
            sse_pkg::ALG_INSERTION:
            begin
                pa_s = j_s;
                pb_s = j_s + spos_t'(1);
            end
            default:
            begin
                pa_s = gp_s - spos_t'(1);
                pb_s = gp_s;
            end
        endcase
    end

    assign gt = rd_a_reg > rd_b_reg;

    // one sort step: position update and exchange decision
    always_comb
    begin
        io_s      = i_s;
        jo_s      = j_s;
        mo_s      = m_s;
        done_next = done_reg;
        swap_go   = 1'b0;
        sa_s      = pa_s;
        sb_s      = pb_s;
        if (!done_reg)
        begin
            case (algorithm_reg)
                sse_pkg::ALG_EXCHANGE:
                begin
                    if (i_s >= n_s)
                    begin
                        done_next = 1'b1;
                    end
                    else if (j_s < spos_t'(0) || j_s >= n_s)
                    begin
                        io_s = i_s + spos_t'(1);
                        jo_s = i_s + spos_t'(1);
                    end
                    else
                    begin
                        swap_go = gt;
                        sa_s    = i_s;
                        sb_s    = j_s;
                        if (j_s + spos_t'(1) >= n_s)
                        begin
                            io_s = i_s + spos_t'(1);
                            jo_s = i_s + spos_t'(1);
                        end
                        else
                        begin
                            jo_s = j_s + spos_t'(1);
                        end
                    end
                end
                sse_pkg::ALG_SELECTION:
                begin
                    if (i_s + spos_t'(1) >= n_s)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        mo_s = mf_s;
                        if (j_s >= spos_t'(0) && j_s < n_s)
                        begin
                            if (gt)
                            begin
                                mo_s = j_s;
                            end
                            jo_s = j_s + spos_t'(1);
                        end
                        // row end: move the minimum to the outer slot
                        if (jo_s < spos_t'(0) || jo_s >= n_s)
                        begin
                            swap_go = 1'b1;
                            sa_s    = i_s;
                            sb_s    = mo_s;
                            io_s    = i_s + spos_t'(1);
                            mo_s    = i_s + spos_t'(1);
                            jo_s    = i_s + spos_t'(2);
                        end
                    end
                end
                sse_pkg::ALG_INSERTION:
                begin
                    if (i_s >= n_s)
                    begin
                        done_next = 1'b1;
                    end
                    else if (i_s == spos_t'(0))
                    begin
                        io_s = spos_t'(1);
                    end
                    else if (j_s >= spos_t'(0) && j_s + spos_t'(1) <= i_s && gt)
                    begin
                        swap_go = 1'b1;
                        sa_s    = j_s;
                        sb_s    = j_s + spos_t'(1);
                        jo_s    = j_s - spos_t'(1);
                    end
                    else
                    begin
                        io_s = i_s + spos_t'(1);
                        jo_s = i_s;
                    end
                end
                default:
                begin
                    if (i_s >= n_s)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        io_s = gp_s;
                        if (gp_s < n_s)
                        begin
                            if (gt)
                            begin
                                swap_go = 1'b1;
                                sa_s    = gp_s - spos_t'(1);
                                sb_s    = gp_s;
                                io_s    = gp_s - spos_t'(1);
                            end
                            else
                            begin
                                io_s = gp_s + spos_t'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign swap_needed  = swap_go && (sa_s != sb_s);
    assign outer_next   = io_s[CW-1:0];
    assign inner_next   = jo_s[CW:0];
    assign minimum_next = mo_s[CW-1:0];

    // request field conversions
    assign idx_wide     = {{AW{1'b0}}, idx_reg};
    assign idx_addr     = idx_wide[AW-1:0];
    assign idx_in_range = 32'(idx_reg) < 32'(MAX_ELEMENTS);
    assign value_wide   = {{VALUE_WIDTH{1'b0}}, value_reg};
    assign read_wide    = {{DW{1'b0}}, rd_a_reg};
    assign read_field   = (req_reg == sse_pkg::REQ_READ && idx_in_range) ?
                          read_wide[DW-1:0] : '0;
    assign first_wide   = {{IW{1'b0}}, swap_a_reg};
    assign second_wide  = {{IW{1'b0}}, swap_b_reg};
    assign first_field  = swap_flag_reg ? first_wide[IW-1:0] : '0;
    assign second_field = swap_flag_reg ? second_wide[IW-1:0] : '0;

    // memory port selection
    assign mem_we      = (cmd.load_write && idx_in_range) || cmd.write_a || cmd.write_b;
    assign mem_re      = cmd.read_issue || cmd.step_read || cmd.swap_read;
    assign mem_waddr   = cmd.load_write ? idx_addr :
                         (cmd.write_a ? swap_a_reg : swap_b_reg);
    assign mem_wdata   = cmd.load_write ? value_wide[VALUE_WIDTH-1:0] :
                         (cmd.write_a ? rd_b_reg : rd_a_reg);
    assign mem_raddr_a = cmd.swap_read ? swap_a_reg :
                         (cmd.step_read ? pa_s[AW-1:0] : idx_addr);
    assign mem_raddr_b = cmd.swap_read ? swap_b_reg : pb_s[AW-1:0];

    // element memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_a_reg <= mem[mem_raddr_a];
            rd_b_reg <= mem[mem_raddr_b];
        end
    end

    // config, sort state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            algorithm_reg <= sse_pkg::ALG_EXCHANGE;
            count_reg     <= sse_pkg::COUNT_RESET;
            outer_reg     <= '0;
            inner_reg     <= '0;
            minimum_reg   <= '0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == sse_pkg::CFG_ALGORITHM)
                begin
                    algorithm_reg <= sse_pkg::alg_t'(cfg_data[sse_pkg::ALG_W-1:0]);
                end
                else
                begin
                    count_reg <= cfg_data;
                end
            end
            if (cmd.restart)
            begin
                outer_reg   <= '0;
                inner_reg   <= '0;
                minimum_reg <= '0;
                done_reg    <= 1'b0;
            end
            else if (cmd.step_commit)
            begin
                outer_reg   <= outer_next;
                inner_reg   <= inner_next;
                minimum_reg <= minimum_next;
                done_reg    <= done_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request capture, exchange pair and output beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg       <= in_req;
            idx_reg       <= in_index;
            value_reg     <= in_value;
            swap_flag_reg <= 1'b0;
        end
        else if (cmd.step_commit)
        begin
            swap_flag_reg <= swap_needed;
            swap_a_reg    <= sa_s[AW-1:0];
            swap_b_reg    <= sb_s[AW-1:0];
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {{sse_pkg::OUT_PAD_W{1'b0}}, read_field, done_reg,
                             second_field, first_field, swap_flag_reg};
        end
    end

    assign status.req         = req_reg;
    assign status.swap_needed = swap_needed;
    assign status.out_free    = !out_valid_reg || out_ready;
    assign out_valid          = out_valid_reg;
    assign out_data           = out_data_reg;

`ifndef NO_ASSERTIONS
    // outer position never runs past the array
    a_outer_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(outer_reg) <= 32'(MAX_ELEMENTS))
        else $error("outer position beyond array");

    // inner position goes at most one below zero
    a_inner_floor: assert property (@(posedge clk) disable iff (!rst_n)
        inner_reg >= -1)
        else $error("inner position below -1");

    // second exchange write follows the first
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_b |-> $past(cmd.write_a))
        else $error("exchange write out of order");

    // a step that exchanges never finishes the sort
    a_swap_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_commit && swap_needed |=> !done_reg)
        else $error("exchange on finishing step");

    // a pending result beat is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output beat overwritten");
`endif

endmodule

>>> sv/stepwise_sort_engine_core.sv
// ----------------------------------------------------------------------------
// stepwise_sort_engine_core
// In-place ascending sort over a loaded array, at most one compare per step request,
// with exchange, selection, insertion or gnome ordering.
// ----------------------------------------------------------------------------
//  channel  signals                        beat contents
//  cfg      cfg_we cfg_index cfg_data      0 algorithm, 1 element count
//  in       s_tvalid s_tready s_tdata      load / step / restart / read
//           s_tuser                        request
//  out      m_tvalid m_tready m_tdata      one result beat per request
//
//  Each request passes through accept, execute and result states; a step
//  adds a compare state, and a step with exchange re-reads the pair and
//  writes each slot in turn (the two-read, single-write element memory sets
//  the exchange cost). A result waiting on m_tready does not block the next
//  accept; only the result after it waits. rst_n clears sort state, config
//  and output valid; element memory keeps no reset and needs no clearing.
// ----------------------------------------------------------------------------
module stepwise_sort_engine_core #(
    parameter int MAX_ELEMENTS = sse_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = sse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sse_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sse_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // elem_index [5:0], elem_value [21:6], zero pad [23:22]
    input  logic [sse_pkg::S_TDATA_W-1:0]    s_tdata,
    // req_type [1:0]
    input  logic [sse_pkg::REQ_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // swapped [0], first_index [6:1], second_index [12:7], sort_done [13],
    // read_data [29:14], zero pad [31:30]
    output logic [sse_pkg::M_TDATA_W-1:0]    m_tdata
);

    sse_pkg::sse_cmd_t    cmd;
    sse_pkg::sse_status_t status;

    // sequencer
    sse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // memory and step logic
    sse_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_req    (sse_pkg::req_t'(s_tuser)),
        .in_index  (s_tdata[5:0]),
        .in_value  (s_tdata[21:6]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

>>> verif/sort_check_pkg.sv
// ----------------------------------------------------------------------------
// sort_check_pkg
// Result prediction and checking for the stepwise sort engine: keeps its own
// copy of the element array, sort positions and config, and compares every
// result beat against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sort_check_pkg;

    import sse_pkg::*;

    // one result beat, field by field
    typedef struct packed {
        logic              swapped;
        logic [IDX_W-1:0]  first_idx;
        logic [IDX_W-1:0]  second_idx;
        logic              sort_done;
        logic [DATA_W-1:0] read_data;
    } sort_result_t;

    class sort_scoreboard;

        logic [DATA_W-1:0]  elem [MAX_ELEMENTS_DEF];
        bit                 written [MAX_ELEMENTS_DEF];
        alg_t               alg;
        logic [COUNT_W-1:0] count;
        logic [6:0]         outer_pos;
        logic signed [7:0]  inner_pos;
        logic [6:0]         min_pos;
        logic               sort_done;
        sort_result_t       expected_q [$];
        int unsigned        errors;
        int unsigned        beats_checked;
        int unsigned        steps_taken;
        int unsigned        exchanges;
        int unsigned        sorts_finished;

        function new();
            alg            = ALG_EXCHANGE;
            count          = COUNT_RESET;
            outer_pos      = '0;
            inner_pos      = '0;
            min_pos        = '0;
            sort_done      = 1'b0;
            errors         = 0;
            beats_checked  = 0;
            steps_taken    = 0;
            exchanges      = 0;
            sorts_finished = 0;
            foreach (written[k])
                written[k] = 1'b0;
        endfunction

        function void set_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_ALGORITHM)
                alg = alg_t'(data[ALG_W-1:0]);
            else
                count = data;
        endfunction

        // count clamped to 1..MAX_ELEMENTS
        function int active_count();
            int n;
            n = count;
            if (n == 0)
                n = 1;
            if (n > MAX_ELEMENTS_DEF)
                n = MAX_ELEMENTS_DEF;
            return n;
        endfunction

        // every element that a step may compare has been loaded
        function bit all_loaded();
            for (int k = 0; k < active_count(); k++)
                if (!written[k])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void swap_pair(int a, int b, inout sort_result_t r);
            logic [DATA_W-1:0] tmp;
            tmp     = elem[a];
            elem[a] = elem[b];
            elem[b] = tmp;
            if (a != b)
            begin
                r.swapped    = 1'b1;
                r.first_idx  = IDX_W'(a);
                r.second_idx = IDX_W'(b);
                exchanges++;
            end
        endfunction

        // one compare of the selected algorithm
        function void advance_sort(inout sort_result_t r);
            int n;
            int i;
            int j;
            int mp;
            n  = active_count();
            i  = outer_pos;
            j  = inner_pos;
            mp = min_pos;
            case (alg)
                ALG_EXCHANGE:
                begin
                    if (i >= n)
                        sort_done = 1'b1;
                    else if (j < 0 || j >= n)
                    begin
                        // stale inner position closes the row
                        i++;
                        outer_pos = 7'(i);
                        inner_pos = 8'(i);
                    end
                    else
                    begin
                        if (elem[i] > elem[j])
                            swap_pair(i, j, r);
                        j++;
                        if (j >= n)
                        begin
                            i++;
                            j = i;
                        end
                        outer_pos = 7'(i);
                        inner_pos = 8'(j);
                    end
                end
                ALG_SELECTION:
                begin
                    if (i + 1 >= n)
                        sort_done = 1'b1;
                    else
                    begin
                        if (mp >= n)
                            mp = i;
                        if (j >= 0 && j < n)
                        begin
                            if (elem[mp] > elem[j])
                                mp = j;
                            j++;
                        end
                        // row end: move the minimum into place
                        if (j < 0 || j >= n)
                        begin
                            swap_pair(i, mp, r);
                            i++;
                            mp = i;
                            j  = i + 1;
                        end
                        outer_pos = 7'(i);
                        inner_pos = 8'(j);
                        min_pos   = 7'(mp);
                    end
                end
                ALG_INSERTION:
                begin
                    if (i >= n)
                        sort_done = 1'b1;
                    else if (i == 0)
                        outer_pos = 7'd1;
                    else
                    begin
                        if (j >= 0 && j + 1 <= i && elem[j] > elem[j+1])
                        begin
                            swap_pair(j, j + 1, r);
                            j--;
                        end
                        else
                        begin
                            i++;
                            j = i - 1;
                        end
                        outer_pos = 7'(i);
                        inner_pos = 8'(j);
                    end
                end
                default:
                begin
                    if (i >= n)
                        sort_done = 1'b1;
                    else
                    begin
                        if (i == 0)
                            i = 1;
                        if (i < n)
                        begin
                            if (elem[i] >= elem[i-1])
                                i++;
                            else
                            begin
                                swap_pair(i - 1, i, r);
                                i--;
                            end
                        end
                        outer_pos = 7'(i);
                    end
                end
            endcase
        endfunction

        // accepted request beat: update state, queue the predicted result
        function void note_request(req_t kind, logic [IDX_W-1:0] idx,
                                   logic [DATA_W-1:0] value);
            sort_result_t r;
            r = '0;
            case (kind)
                REQ_LOAD:
                begin
                    elem[idx]    = value;
                    written[idx] = 1'b1;
                end
                REQ_STEP:
                begin
                    if (!sort_done)
                    begin
                        steps_taken++;
                        advance_sort(r);
                        if (sort_done)
                            sorts_finished++;
                    end
                end
                REQ_RESTART:
                begin
                    outer_pos = '0;
                    inner_pos = '0;
                    min_pos   = '0;
                    sort_done = 1'b0;
                end
                default:
                    r.read_data = elem[idx];
            endcase
            r.sort_done = sort_done;
            expected_q = {expected_q, r};
        endfunction

        // accepted result beat against the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] beat);
            sort_result_t got;
            sort_result_t want;
            bit           bad;
            got.swapped    = beat[0];
            got.first_idx  = beat[6:1];
            got.second_idx = beat[12:7];
            got.sort_done  = beat[13];
            got.read_data  = beat[29:14];
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result beat %h with nothing expected", $time, beat);
                return;
            end
            want = expected_q.pop_front();
            beats_checked++;
            bad = (got.swapped !== want.swapped) || (got.first_idx !== want.first_idx) ||
                  (got.second_idx !== want.second_idx) ||
                  (got.sort_done !== want.sort_done) || (got.read_data !== want.read_data);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: result %0d mismatch (expected/actual): swapped %0d/%0d first %0d/%0d",
                             $time, beats_checked, want.swapped, got.swapped,
                             want.first_idx, got.first_idx);
                    $display("    second %0d/%0d done %0d/%0d data %h/%h",
                             want.second_idx, got.second_idx, want.sort_done, got.sort_done,
                             want.read_data, got.read_data);
                end
            end
        endfunction

    endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the stepwise sort engine: loads arrays, steps every
// algorithm up to a step cap over many element counts, reads results back,
// and checks each result beat under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import sse_pkg::*;
    import sort_check_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1050;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [REQ_W-1:0]       s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;

    sort_scoreboard sb;
    bit             steady;
    int             holds_wanted;
    int             holds_done;
    int             idle_cycles;
    int             items_sent;
    int             settings_used;

    stepwise_sort_engine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result checking and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result sink: random ready runs, plus long holds on request
    initial
    begin
        int   len;
        int   roll;
        logic lvl;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done < holds_wanted)
            begin
                lvl = 1'b0;
                len = HOLD_CYCLES;
                holds_done++;
            end
            else if (steady)
            begin
                lvl = 1'b1;
                len = 1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                begin
                    lvl = 1'b1;
                    len = $urandom_range(1, 8);
                end
                else if (roll < 92)
                begin
                    lvl = 1'b0;
                    len = $urandom_range(1, 3);
                end
                else
                begin
                    lvl = 1'b0;
                    len = $urandom_range(10, 40);
                end
            end
            @(negedge clk);
            m_tready <= lvl;
            repeat (len - 1) @(negedge clk);
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // element values: full range, heavy duplicates and the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return DATA_W'($urandom);
        if (roll < 70)
            return DATA_W'($urandom_range(0, 3));
        if (roll < 85)
            return '0;
        return '1;
    endfunction

    // a loaded index, or -1 when none is
    function automatic int pick_loaded();
        int start;
        start = $urandom_range(0, MAX_ELEMENTS_DEF - 1);
        for (int k = 0; k < MAX_ELEMENTS_DEF; k++)
            if (sb.written[(start + k) % MAX_ELEMENTS_DEF])
                return (start + k) % MAX_ELEMENTS_DEF;
        return -1;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return COUNT_W'($urandom_range(1, 10));
        if (roll < 70)
            return COUNT_W'($urandom_range(11, 20));
        if (roll < 80)
            return COUNT_W'(MAX_ELEMENTS_DEF);
        if (roll < 86)
            return '0;
        if (roll < 92)
            return COUNT_W'($urandom_range(65, 127));
        return COUNT_W'($urandom_range(21, 63));
    endfunction

    // one request beat, held until accepted
    task automatic send_req(input req_t kind, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(kind, idx, value);
        items_sent++;
    endtask

    // stop offering and wait until every result has come back
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_config(index, data);
    endtask

    // stray read, load or restart in the middle of a sort
    task automatic noise_item();
        int roll;
        int pos;
        roll = $urandom_range(0, 99);
        pos  = pick_loaded();
        if (roll < 45 && pos >= 0)
            send_req(REQ_READ, IDX_W'(pos), DATA_W'($urandom));
        else if (roll < 95)
            send_req(REQ_LOAD, IDX_W'($urandom), pick_value());
        else
            send_req(REQ_RESTART, IDX_W'($urandom), DATA_W'($urandom));
    endtask

    // one setting: config, fill, step to completion, read back
    task automatic run_phase(input int phase_no);
        int                n;
        int                cap;
        int                steps;
        int                pattern;
        bit                hold_phase;
        logic [ALG_W-1:0]  alg_code;
        logic [COUNT_W-1:0] cnt;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] stride;
        hold_phase = (phase_no == 2 || phase_no == 6);
        drain();
        steady   = ($urandom_range(0, 3) == 0) && !hold_phase;
        alg_code = (phase_no < 8) ? ALG_W'(phase_no) : ALG_W'($urandom);
        cfg_write(CFG_ALGORITHM, {5'($urandom), alg_code});
        // early phases pin the count extremes
        case (phase_no)
            0:       cnt = 7'd1;
            1:       cnt = 7'(MAX_ELEMENTS_DEF);
            3:       cnt = 7'd0;
            5:       cnt = 7'd127;
            2, 6:    cnt = 7'd10;
            default: cnt = pick_count();
        endcase
        if (phase_no % 5 != 4 || hold_phase)
            cfg_write(CFG_COUNT, cnt);
        settings_used++;
        // without a restart the sort resumes from stale positions
        if (hold_phase || $urandom_range(0, 4) != 0)
            send_req(REQ_RESTART, IDX_W'($urandom), DATA_W'($urandom));
        n = sb.active_count();
        if (!sb.all_loaded() || $urandom_range(0, 9) < 7)
        begin
            pattern = $urandom_range(0, 3);
            base    = DATA_W'($urandom);
            stride  = DATA_W'($urandom_range(0, 1000));
            for (int k = 0; k < n; k++)
            begin
                case (pattern)
                    0:       send_req(REQ_LOAD, IDX_W'(k), pick_value());
                    1:       send_req(REQ_LOAD, IDX_W'(k), base - DATA_W'(k) * stride);
                    2:       send_req(REQ_LOAD, IDX_W'(k), base + DATA_W'(k) * stride);
                    default: send_req(REQ_LOAD, IDX_W'(k), base);
                endcase
            end
        end
        if (hold_phase)
            holds_wanted++;
        // big arrays only get a bounded number of steps
        cap   = (n <= 12) ? 4 * n * n + 8 : 120;
        steps = 0;
        while (!sb.sort_done && steps < cap)
        begin
            if ($urandom_range(0, 99) < 8)
                noise_item();
            else
            begin
                send_req(REQ_STEP, IDX_W'($urandom), DATA_W'($urandom));
                steps++;
            end
            if (!sb.all_loaded())
                break;
        end
        // steps after done change nothing
        if (sb.sort_done)
            repeat ($urandom_range(1, 2))
                send_req(REQ_STEP, IDX_W'($urandom), DATA_W'($urandom));
        for (int k = 0; k < n && k < 12; k++)
            if (sb.written[k])
                send_req(REQ_READ, IDX_W'(k), DATA_W'($urandom));
    endtask

    // stimulus
    initial
    begin
        int phase_no;
        int directed_items;
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: value and index extremes, a full exchange sort of four
        cfg_write(CFG_ALGORITHM, 7'(ALG_EXCHANGE));
        cfg_write(CFG_COUNT, 7'd4);
        send_req(REQ_LOAD, 6'd0, 16'hFFFF);
        send_req(REQ_LOAD, 6'd1, 16'h0000);
        send_req(REQ_LOAD, 6'd2, 16'h5555);
        send_req(REQ_LOAD, 6'd3, 16'hAAAA);
        send_req(REQ_LOAD, 6'd63, 16'h8001);
        send_req(REQ_READ, 6'd63, 16'h0000);
        send_req(REQ_READ, 6'd0, 16'h0000);
        for (int k = 0; k < 20 && !sb.sort_done; k++)
            send_req(REQ_STEP, 6'd0, 16'h0000);
        send_req(REQ_STEP, 6'h3F, 16'hFFFF);
        send_req(REQ_RESTART, 6'd0, 16'h0000);
        // a count of zero acts as one: selection finishes at once
        drain();
        cfg_write(CFG_ALGORITHM, 7'(ALG_SELECTION));
        cfg_write(CFG_COUNT, 7'd0);
        send_req(REQ_STEP, 6'd0, 16'h0000);
        send_req(REQ_READ, 6'd1, 16'h0000);
        directed_items = items_sent;

        // random settings until the item budget is spent
        phase_no = 0;
        while (items_sent < directed_items + RANDOM_ITEMS)
        begin
            run_phase(phase_no);
            phase_no++;
        end
        drain();
        repeat (20) @(posedge clk);

        $display("tb summary: %0d requests over %0d settings, %0d sort steps, %0d exchanges",
                 items_sent, settings_used, sb.steps_taken, sb.exchanges);
        $display("tb summary: %0d sorts completed, %0d result beats checked, %0d mismatches",
                 sb.sorts_finished, sb.beats_checked, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
